// File: rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and fixed constants of the TLB page-table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // Widths of the request and result words.
    localparam int VA_W       = 16;
    localparam int PA_W       = 16;
    localparam int TOTAL_W    = 16;

    // Physical frames are handed out in order from zero.
    localparam int FRAME_W    = 8;
    localparam int NUM_FRAMES = 256;
    localparam int FREE_W     = 9;

    typedef logic [VA_W-1:0]    t_vaddr;
    typedef logic [PA_W-1:0]    t_paddr;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [FREE_W-1:0]  t_free;

    // One page-table entry as held in the RAM.
    typedef struct packed {
        logic   present;
        t_frame frame;
    } t_pt_entry;

endpackage

// File: rtl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Translates virtual addresses through a page table and a FIFO-replaced TLB.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_valid / o_ready) carries one virtual address; its
// upper PAGE_BITS bits above the low OFFSET_BITS bits name the page. The
// result channel (o_valid / i_ready) returns the physical address, the TLB
// hit and page-fault flags and three saturating running totals.
// A page without a page-table entry gets the next free frame; once all 256
// frames are given out such a page stays unmapped and translates to frame 0.
// For each request the page-table RAM is read in the accept cycle; the
// registered entry is then checked, updated and written back together
// with the TLB lookup and fill once the result register can take it. A
// new request is accepted only after that, so one is in flight at a time.
// The result sits in an output register; a stalled receiver holds the
// finished request in the second stage, and o_ready stays low until the
// result register can take it.
// After reset all 2**PAGE_BITS page-table entries (256 by default) are
// cleared one entry per cycle; o_ready is low during that pass.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BITS   = 8,
    parameter int OFFSET_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tlbpt_pkg::t_vaddr  i_virtual_address,
    output logic               o_valid,
    input  logic               i_ready,
    output tlbpt_pkg::t_paddr  o_physical_address,
    output logic               o_tlb_hit,
    output logic               o_page_fault,
    output tlbpt_pkg::t_total  o_hit_total,
    output tlbpt_pkg::t_total  o_fault_total,
    output tlbpt_pkg::t_total  o_translated_total
);

    import tlbpt_pkg::*;

    localparam int PT_DEPTH = 1 << PAGE_BITS;
    localparam int SLOT_W   = $clog2(TLB_ENTRIES);
    localparam int FILL_W   = $clog2(TLB_ENTRIES + 1);
    localparam int VAX_W    = (PAGE_BITS + OFFSET_BITS > VA_W) ?
                              PAGE_BITS + OFFSET_BITS : VA_W;
    localparam int PAX_W    = (FRAME_W + OFFSET_BITS > PA_W) ?
                              FRAME_W + OFFSET_BITS : PA_W;

    // Control state.
    logic                   r_clearing;
    logic [PAGE_BITS-1:0]   r_clr_addr;
    logic                   r_busy;
    logic                   r_out_valid;
    t_free                  r_next_free;
    logic [FILL_W-1:0]      r_fill;
    logic [SLOT_W-1:0]      r_repl;
    t_total                 r_hit_total;
    t_total                 r_fault_total;
    t_total                 r_xlat_total;

    // Payload state.
    logic [PAGE_BITS-1:0]   r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [PAGE_BITS-1:0]   r_tag [TLB_ENTRIES];
    t_paddr                 r_pa;
    logic                   r_hit;
    logic                   r_fault;

    logic                   accept;
    logic                   done;
    logic                   out_take;
    logic [VAX_W-1:0]       va_ext;
    logic [PAGE_BITS-1:0]   in_page;
    logic [OFFSET_BITS-1:0] in_offset;
    logic [$bits(t_pt_entry)-1:0] rd_data;
    t_pt_entry              pt_entry;
    logic                   can_alloc;
    logic                   fault;
    logic                   mapped;
    t_frame                 frame;
    logic [TLB_ENTRIES-1:0] match;
    logic                   hit;
    logic                   tlb_full;
    logic                   tlb_load;
    logic [SLOT_W-1:0]      slot;
    logic [PAX_W-1:0]       pa_ext;
    logic                   wr_en;
    logic [PAGE_BITS-1:0]   wr_addr;
    t_pt_entry              wr_entry;

    // Handshakes. One request is in flight at a time, so a page-table write
    // back always lands before the next read of the RAM.
    assign o_ready  = !r_busy && !r_clearing;
    assign accept   = i_valid && o_ready;
    assign out_take = r_out_valid && i_ready;
    assign done     = r_busy && (!r_out_valid || i_ready);

    // Split the virtual address; bits beyond page and offset are ignored.
    assign va_ext    = VAX_W'(i_virtual_address);
    assign in_page   = va_ext[OFFSET_BITS +: PAGE_BITS];
    assign in_offset = va_ext[OFFSET_BITS-1:0];

    // Page-table entry check and frame allocation.
    assign pt_entry  = t_pt_entry'(rd_data);
    assign can_alloc = r_next_free < FREE_W'(NUM_FRAMES);
    assign fault     = !pt_entry.present && can_alloc;
    assign mapped    = pt_entry.present || fault;

    always_comb begin
        if (pt_entry.present) begin
            frame = pt_entry.frame;
        end else if (fault) begin
            frame = r_next_free[FRAME_W-1:0];
        end else begin
            frame = '0;
        end
    end

    // Fully associative lookup. Slots fill in order and never empty, so a
    // slot is valid exactly when its index is below the fill count. The
    // frame of a hit equals the page-table frame, so no frame is kept here.
    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            match[i] = (FILL_W'(i) < r_fill) && (r_tag[i] == r_page);
        end
    end

    assign hit      = |match;
    assign tlb_full = r_fill == FILL_W'(TLB_ENTRIES);
    assign tlb_load = done && !hit && mapped;
    assign slot     = tlb_full ? r_repl : r_fill[SLOT_W-1:0];

    assign pa_ext   = PAX_W'({frame, r_offset});

    // Page-table write port, shared by the clearing pass and allocation.
    assign wr_en    = r_clearing || (done && fault);
    assign wr_addr  = r_clearing ? r_clr_addr : r_page;
    assign wr_entry = r_clearing ? t_pt_entry'('0) :
                      t_pt_entry'{present: 1'b1, frame: r_next_free[FRAME_W-1:0]};

    tlbpt_ram #(
        .WIDTH ($bits(t_pt_entry)),
        .DEPTH (PT_DEPTH)
    ) u_page_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (accept),
        .i_rd_addr (in_page),
        .o_rd_data (rd_data)
    );

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {PAGE_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Request capture and stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page   <= in_page;
            r_offset <= in_offset;
        end
    end

    // Frame allocator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
        end else if (done && fault) begin
            r_next_free <= r_next_free + 1'b1;
        end
    end

    // TLB fill count, FIFO pointer and tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_repl <= '0;
        end else if (tlb_load) begin
            if (!tlb_full) begin
                r_fill <= r_fill + 1'b1;
            end else if (r_repl == SLOT_W'(TLB_ENTRIES - 1)) begin
                r_repl <= '0;
            end else begin
                r_repl <= r_repl + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tlb_load) begin
            r_tag[slot] <= r_page;
        end
    end

    // Result register and saturating totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_hit_total   <= '0;
            r_fault_total <= '0;
            r_xlat_total  <= '0;
        end else if (done) begin
            r_out_valid <= 1'b1;
            if (hit && r_hit_total != '1) begin
                r_hit_total <= r_hit_total + 1'b1;
            end
            if (fault && r_fault_total != '1) begin
                r_fault_total <= r_fault_total + 1'b1;
            end
            if (r_xlat_total != '1) begin
                r_xlat_total <= r_xlat_total + 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_pa    <= pa_ext[PA_W-1:0];
            r_hit   <= hit;
            r_fault <= fault;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_pa;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_hit_total        = r_hit_total;
    assign o_fault_total      = r_fault_total;
    assign o_translated_total = r_xlat_total;

endmodule

// File: rtl/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks of the TLB page-table translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbpt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  tlbpt_pkg::t_vaddr  i_virtual_address,
    input  logic               o_valid,
    input  logic               i_ready,
    input  tlbpt_pkg::t_paddr  o_physical_address,
    input  logic               o_tlb_hit,
    input  logic               o_page_fault,
    input  tlbpt_pkg::t_total  o_hit_total,
    input  tlbpt_pkg::t_total  o_fault_total,
    input  tlbpt_pkg::t_total  o_translated_total
);

    import tlbpt_pkg::*;

    // A page that just got its frame cannot already sit in the TLB.
    a_hit_excludes_fault: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tlb_hit && o_page_fault)
    ) else $error("TLB hit reported together with a page fault");

    // Only one request is in flight: no request right after an accept.
    a_one_in_flight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("request accepted in two consecutive cycles");

    // Hit and fault totals never run ahead of the translated total.
    a_totals_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_total <= o_translated_total) &&
                    (o_fault_total <= o_translated_total)
    ) else $error("running totals out of order");

    // A stalled result holds its payload.
    a_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_physical_address)
                                 && $stable(o_translated_total)
    ) else $error("stalled result changed");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

// File: dv/tlb_page_table_translator_checker.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator_checker
// Watches the request and result channels of the translator, keeps its own
// copy of the page table, the TLB and the running totals, and compares every
// result field by field with the translation predicted for its request.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  tlbpt_pkg::t_vaddr i_virtual_address,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  tlbpt_pkg::t_paddr i_physical_address,
    input  logic              i_tlb_hit,
    input  logic              i_page_fault,
    input  tlbpt_pkg::t_total i_hit_total,
    input  tlbpt_pkg::t_total i_fault_total,
    input  tlbpt_pkg::t_total i_translated_total,
    output int                o_fail_count,
    output int                o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import tlbpt_pkg::*;

    localparam int TLB_N    = 16;
    localparam int PAGE_W   = 8;
    localparam int OFFSET_W = 8;
    localparam int PAGES    = 1 << PAGE_W;

    typedef logic [PAGE_W-1:0] t_page;

    // One predicted result.
    typedef struct {
        t_paddr physical_address;
        logic   tlb_hit;
        logic   page_fault;
        t_total hit_total;
        t_total fault_total;
        t_total translated_total;
    } t_translation;

    // Predicted page table, TLB and totals.
    logic [PAGES-1:0]       pt_present;
    t_frame                 pt_frame [PAGES];
    t_free                  next_frame;
    logic [TLB_N-1:0]       tlb_valid;
    t_page                  tlb_page [TLB_N];
    t_frame                 tlb_frame [TLB_N];
    logic [$clog2(TLB_N)-1:0] fifo_ptr;
    t_total                 hits_seen;
    t_total                 faults_seen;
    t_total                 requests_seen;

    t_translation           pending_translations [$];
    t_translation           oldest;

    function automatic void clear_tables();
        pt_present    = '0;
        tlb_valid     = '0;
        next_frame    = '0;
        fifo_ptr      = '0;
        hits_seen     = '0;
        faults_seen   = '0;
        requests_seen = '0;
    endfunction

    // Translate one address and advance the predicted state.
    function automatic t_translation translate_address(input t_vaddr va);
        t_translation r;
        t_page        page;
        t_frame       frame;
        logic         hit;
        logic         fault;
        int           empty_slot;
        int           slot;
        page       = va[OFFSET_W +: PAGE_W];
        frame      = '0;
        hit        = 1'b0;
        fault      = 1'b0;
        empty_slot = -1;

        // A page without an entry gets the next free frame while any remain.
        if (!pt_present[page] && next_frame < NUM_FRAMES) begin
            pt_present[page] = 1'b1;
            pt_frame[page]   = next_frame[FRAME_W-1:0];
            next_frame       = next_frame + 1'b1;
            fault            = 1'b1;
        end

        // Associative search; remember the first free slot on the way.
        for (int i = 0; i < TLB_N; i++) begin
            if (tlb_valid[i] && tlb_page[i] == page) begin
                hit   = 1'b1;
                frame = tlb_frame[i];
                break;
            end
            if (!tlb_valid[i] && empty_slot < 0) begin
                empty_slot = i;
            end
        end

        // On a miss of a mapped page, fill a free slot or evict the oldest.
        if (!hit && pt_present[page]) begin
            frame = pt_frame[page];
            if (empty_slot >= 0) begin
                slot = empty_slot;
            end else begin
                slot     = fifo_ptr;
                fifo_ptr = fifo_ptr + 1'b1;
            end
            tlb_valid[slot] = 1'b1;
            tlb_page[slot]  = page;
            tlb_frame[slot] = frame;
        end

        // Running totals stop at their maximum.
        if (hit && hits_seen != '1) begin
            hits_seen = hits_seen + 1'b1;
        end
        if (fault && faults_seen != '1) begin
            faults_seen = faults_seen + 1'b1;
        end
        if (requests_seen != '1) begin
            requests_seen = requests_seen + 1'b1;
        end

        r.physical_address = {frame, va[OFFSET_W-1:0]};
        r.tlb_hit          = hit;
        r.page_fault       = fault;
        r.hit_total        = hits_seen;
        r.fault_total      = faults_seen;
        r.translated_total = requests_seen;
        return r;
    endfunction

    // Handshakes are sampled on the falling edge before the edge that takes them,
    // when every signal is settled.  Results are matched before a request of
    // the same edge is added, so a result can never match its own request.
    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        clear_tables();
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            clear_tables();
            pending_translations.delete();
        end else begin
            if (i_rsp_valid === 1'b1 && i_rsp_ready === 1'b1) begin
                if (pending_translations.size() == 0) begin
                    $error("result with no request outstanding: physical_address %h",
                           i_physical_address);
                    o_fail_count++;
                end else begin
                    oldest = pending_translations.pop_front();
                    if (i_physical_address !== oldest.physical_address) begin
                        $error("physical_address: expected %h, got %h",
                               oldest.physical_address, i_physical_address);
                        o_fail_count++;
                    end
                    if (i_tlb_hit !== oldest.tlb_hit) begin
                        $error("tlb_hit: expected %b, got %b", oldest.tlb_hit, i_tlb_hit);
                        o_fail_count++;
                    end
                    if (i_page_fault !== oldest.page_fault) begin
                        $error("page_fault: expected %b, got %b",
                               oldest.page_fault, i_page_fault);
                        o_fail_count++;
                    end
                    if (i_hit_total !== oldest.hit_total) begin
                        $error("hit_total: expected %0d, got %0d",
                               oldest.hit_total, i_hit_total);
                        o_fail_count++;
                    end
                    if (i_fault_total !== oldest.fault_total) begin
                        $error("fault_total: expected %0d, got %0d",
                               oldest.fault_total, i_fault_total);
                        o_fail_count++;
                    end
                    if (i_translated_total !== oldest.translated_total) begin
                        $error("translated_total: expected %0d, got %0d",
                               oldest.translated_total, i_translated_total);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid === 1'b1 && i_req_ready === 1'b1) begin
                pending_translations.push_back(translate_address(i_virtual_address));
            end
        end
        o_outstanding = pending_translations.size();
    end

endmodule

// File: dv/tlb_page_table_translator_tb.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator_tb
// Drives virtual addresses into the translator with random gaps and result
// stalls: a directed opening that fills and overflows the TLB, a random run
// with page locality, a drain pause, a short back-to-back burst on one page
// with a receiver that never stalls, and random addresses to close.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tlbpt_pkg::*;

    localparam int RANDOM_REQUESTS = 980;
    localparam int BURST_REQUESTS  = 20;
    localparam int AFTER_BURST     = 30;
    localparam int HOT_PAGES       = 24;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_vaddr i_virtual_address;
    logic   o_valid;
    logic   i_ready;
    t_paddr o_physical_address;
    logic   o_tlb_hit;
    logic   o_page_fault;
    t_total o_hit_total;
    t_total o_fault_total;
    t_total o_translated_total;

    int     fail_count;
    int     outstanding;
    int     stuck_cycles;

    // Stimulus pacing controls.
    logic   sink_fast;
    int     src_streak;
    int     sink_streak;
    int     sink_stall;

    logic [7:0] hot_page [HOT_PAGES];
    int         hot_count;
    int         pick;
    logic [7:0] page;
    logic [7:0] offset;

    tlb_page_table_translator u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_virtual_address  (i_virtual_address),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total),
        .o_translated_total (o_translated_total)
    );

    tlb_page_table_translator_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_virtual_address  (i_virtual_address),
        .i_rsp_valid        (o_valid),
        .i_rsp_ready        (i_ready),
        .i_physical_address (o_physical_address),
        .i_tlb_hit          (o_tlb_hit),
        .i_page_fault       (o_page_fault),
        .i_hit_total        (o_hit_total),
        .i_fault_total      (o_fault_total),
        .i_translated_total (o_translated_total),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Send one request, starting and ending at a rising edge.  A random gap
    // comes first unless no_gap is set or a no-gap streak is running.
    task automatic issue_request(input t_vaddr va, input logic no_gap);
        int gap;
        if (no_gap || src_streak != 0) begin
            gap = 0;
            if (src_streak != 0) begin
                src_streak--;
            end
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 29) == 0) begin
                src_streak = $urandom_range(10, 40);
            end
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_virtual_address <= va;
        @(negedge i_clk);
        while (o_ready !== 1'b1) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Result side: a random stall per result, with runs of no stalls.
    initial begin
        i_ready     = 1'b0;
        sink_streak = 0;
        @(posedge i_clk);
        forever begin
            if (sink_fast || sink_streak != 0) begin
                sink_stall = 0;
                if (sink_streak != 0) begin
                    sink_streak--;
                end
            end else begin
                sink_stall = $urandom_range(0, 10);
                if ($urandom_range(0, 29) == 0) begin
                    sink_streak = $urandom_range(10, 40);
                end
            end
            if (sink_stall != 0) begin
                i_ready <= 1'b0;
                repeat (sink_stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(negedge i_clk);
            while (o_valid !== 1'b1) begin
                @(negedge i_clk);
            end
            @(posedge i_clk);
        end
    end

    // Watchdog: too many cycles in a row with no request or result taken.
    initial begin
        stuck_cycles = 0;
    end

    always @(negedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) ||
            (o_valid === 1'b1 && i_ready === 1'b1)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main stimulus.
    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_virtual_address = '0;
        sink_fast         = 1'b0;
        src_streak        = 0;
        hot_count         = HOT_PAGES;
        for (int i = 0; i < HOT_PAGES; i++) begin
            hot_page[i] = 8'($urandom_range(0, 255));
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Opening: extremes of page and offset, hits right after the first
        // fault of a page, then enough distinct pages to fill the TLB and
        // force FIFO eviction, then a miss on an evicted but mapped page.
        issue_request(16'h0000, 1'b0);
        issue_request(16'h0000, 1'b0);
        issue_request(16'hFFFF, 1'b0);
        issue_request(16'hFF00, 1'b0);
        issue_request(16'h00FF, 1'b0);
        issue_request(16'h80A5, 1'b0);
        issue_request(16'h7F5A, 1'b0);
        for (int p = 1; p <= 13; p++) begin
            issue_request({p[7:0], (p % 2) ? 8'h55 : 8'hAA}, 1'b0);
        end
        issue_request(16'h0042, 1'b0);
        issue_request(16'hFF11, 1'b0);

        // Random run: mostly a hot set of pages, whose size changes now and
        // then around the TLB size, plus uniform pages and the extremes.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0) begin
                hot_count = $urandom_range(2, HOT_PAGES);
                for (int k = 0; k < 4; k++) begin
                    hot_page[$urandom_range(0, HOT_PAGES - 1)] = 8'($urandom_range(0, 255));
                end
            end
            // Halfway, hold off until every result is back.
            if (n == RANDOM_REQUESTS / 2) begin
                i_valid <= 1'b0;
                wait (outstanding == 0);
                @(posedge i_clk);
            end
            pick   = $urandom_range(0, 9);
            offset = 8'($urandom_range(0, 255));
            if (pick < 6) begin
                page = hot_page[$urandom_range(0, hot_count - 1)];
            end else if (pick < 9) begin
                page = 8'($urandom_range(0, 255));
            end else begin
                page   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                offset = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            issue_request({page, offset}, 1'b0);
        end

        // Burst: back-to-back requests on one page with a receiver that
        // never stalls, then mixed requests follow.
        sink_fast <= 1'b1;
        for (int n = 0; n < BURST_REQUESTS; n++) begin
            issue_request({8'h5A, 8'($urandom_range(0, 255))}, 1'b1);
        end
        sink_fast <= 1'b0;
        for (int n = 0; n < AFTER_BURST; n++) begin
            issue_request(16'($urandom_range(0, 65535)), 1'b0);
        end
        i_valid <= 1'b0;

        // Drain and give the verdict.
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
